// ----- src/epc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// epc_pkg: shared types and constants
// Field widths, register indexes and input modes of the eye pixel compositor.
// ----------------------------------------------------------------------------
package epc_pkg;

    localparam int TEX_SIZE_D    = 128;
    localparam int OUT_SIZE_D    = 160;
    localparam int SCLERA_SIZE_D = 256;
    localparam int IRIS_SIZE_D   = 128;
    localparam int IRIS_MAP_W_D  = 256;
    localparam int IRIS_MAP_H_D  = 64;

    localparam int MODE_W  = 3;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 16;
    localparam int COORD_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int LID_LIMIT_CUT = 200;

    typedef enum logic [MODE_W-1:0] {
        MODE_UPPER  = 3'd0,
        MODE_LOWER  = 3'd1,
        MODE_SCLERA = 3'd2,
        MODE_POLAR  = 3'd3,
        MODE_MAP    = 3'd4,
        MODE_RENDER = 3'd5
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EYE_SIDE  = 3'd0,
        REG_IRIS_SCL  = 3'd1,
        REG_SCL_OFS_X = 3'd2,
        REG_SCL_OFS_Y = 3'd3,
        REG_UPPER_THR = 3'd4,
        REG_LOWER_THR = 3'd5
    } t_reg_idx;

endpackage
`default_nettype wire

// ----- src/epc_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// epc_in_if: input channel
// Load and render transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface epc_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] load_address;
    logic [15:0] load_data;
    logic [7:0]  screen_x;
    logic [7:0]  screen_y;
    modport source (output valid, mode, load_address, load_data, screen_x, screen_y,
                    input ready);
    modport sink (input valid, mode, load_address, load_data, screen_x, screen_y,
                  output ready);
endinterface
`default_nettype wire

// ----- src/epc_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// epc_out_if: output channel
// Rendered pixel transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface epc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    modport source (output valid, pixel_color, pixel_x, pixel_y, input ready);
    modport sink (input valid, pixel_color, pixel_x, pixel_y, output ready);
endinterface
`default_nettype wire

// ----- src/eye_pixel_compositor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// eye_pixel_compositor: polar-mapped eye renderer
// Texture stores in block RAM, four-stage render pipeline with output skid.
// ----------------------------------------------------------------------------
// One transaction per clock unless stalled: loads write a store, renders
// pass a pipeline of coordinate scaling, lid/polar read, mask and iris-map
// scale, iris/sclera read, then select into a two-entry output skid buffer.
// A rendered pixel passes stage registers 1 to 4 before it enters the skid.
// Each load is delayed to the stage where its store is read, so a render
// sees exactly the loads taken before it. The input stalls while the skid
// buffer is full; input ready is taken from the skid state alone, so output
// ready never reaches it combinationally, and after a full stall the input
// is taken again once the skid count drops. Stores power up undefined; no
// clearing pass is run.
module eye_pixel_compositor #(
    parameter int TEX_SIZE    = epc_pkg::TEX_SIZE_D,
    parameter int OUT_SIZE    = epc_pkg::OUT_SIZE_D,
    parameter int SCLERA_SIZE = epc_pkg::SCLERA_SIZE_D,
    parameter int IRIS_SIZE   = epc_pkg::IRIS_SIZE_D,
    parameter int IRIS_MAP_W  = epc_pkg::IRIS_MAP_W_D,
    parameter int IRIS_MAP_H  = epc_pkg::IRIS_MAP_H_D
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [epc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [epc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    epc_in_if.sink                             in_ch,
    epc_out_if.source                          out_ch
);
    import epc_pkg::*;

    localparam int LID_D = TEX_SIZE * TEX_SIZE;
    localparam int SCL_D = SCLERA_SIZE * SCLERA_SIZE;
    localparam int POL_D = IRIS_SIZE * IRIS_SIZE;
    localparam int MAP_D = IRIS_MAP_W * IRIS_MAP_H;
    localparam int LID_AW = $clog2(LID_D);
    localparam int SCL_AW = $clog2(SCL_D);
    localparam int POL_AW = $clog2(POL_D);
    localparam int MAP_AW = $clog2(MAP_D);
    localparam int TW  = $clog2(TEX_SIZE);
    localparam int SW  = $clog2(SCLERA_SIZE);
    localparam int IW  = $clog2(IRIS_SIZE);
    localparam int MWW = $clog2(IRIS_MAP_W);
    localparam int MHW = $clog2(IRIS_MAP_H);
    localparam int MARGIN = (SCLERA_SIZE - IRIS_SIZE) / 2;
    localparam int SUMW = 11;   // offset (8) + tex coord (<=8) + sign
    localparam int DPROD = 17;  // 10-bit scale x 7-bit radius
    // reciprocal of OUT_SIZE/TEX_SIZE, rounded up; exact for 8-bit values
    // since 2^RK exceeds 255 * OUT_SIZE
    localparam int RK = 17;
    localparam int RM = ((1 << RK) * TEX_SIZE + OUT_SIZE - 1) / OUT_SIZE;

    // ---------------- configuration ----------------
    logic       r_eye_side;
    logic [9:0] r_iris_scale;
    logic [7:0] r_ofs_x, r_ofs_y, r_upper_thr, r_lower_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_side   <= 1'b0;
            r_iris_scale <= 10'd512;
            r_ofs_x      <= 8'd64;
            r_ofs_y      <= 8'd64;
            r_upper_thr  <= 8'd0;
            r_lower_thr  <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EYE_SIDE:  r_eye_side   <= i_cfg_data[0];
                REG_IRIS_SCL:  r_iris_scale <= i_cfg_data[9:0];
                REG_SCL_OFS_X: r_ofs_x      <= i_cfg_data[7:0];
                REG_SCL_OFS_Y: r_ofs_y      <= i_cfg_data[7:0];
                REG_UPPER_THR: r_upper_thr  <= i_cfg_data[7:0];
                REG_LOWER_THR: r_lower_thr  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // floor(s * TEX_SIZE / OUT_SIZE)
    function automatic logic [31-RK:0] tex_scale(input logic [7:0] s);
        logic [31:0] p;
        p = 32'(s) * 32'(RM);
        return p[31:RK];
    endfunction

    // threshold scaling, registered once
    function automatic logic [7:0] lid_limit(input logic [7:0] t);
        logic [31-RK:0] q;
        q = tex_scale(t);
        if (OUT_SIZE > TEX_SIZE && int'(t) < LID_LIMIT_CUT)
            return q[7:0];
        return t;
    endfunction

    logic [7:0] r_upper_lim, r_lower_lim;
    always_ff @(posedge i_clk) begin
        r_upper_lim <= lid_limit(r_upper_thr);
        r_lower_lim <= lid_limit(r_lower_thr);
    end

    // ---------------- pipeline control ----------------
    // stage valids v1..v4; out skid holds two entries
    logic [3:0] r_v;
    logic [15:0] r_q_col [2];
    logic [7:0]  r_q_x [2], r_q_y [2];
    logic [1:0]  r_q_cnt;
    logic        r_q_rd;
    logic        adv, acc, s5_push, pop;

    // advance while the skid has room for whatever leaves stage 4
    assign adv = r_q_cnt != 2'd2;
    assign in_ch.ready = adv;
    assign acc = in_ch.valid && in_ch.ready;
    assign pop = out_ch.valid && out_ch.ready;

    logic is_render;
    assign is_render = acc && (in_ch.mode == MODE_RENDER);

    // ---------------- stage 1: tex coords ----------------
    function automatic logic [TW-1:0] to_tex(input logic [7:0] s);
        logic [31-RK:0] v;
        v = tex_scale(s);
        if (32'(v) >= 32'(TEX_SIZE)) return TW'(TEX_SIZE - 1);
        return v[TW-1:0];
    endfunction

    logic [TW-1:0] r1_tx, r1_ty;
    logic [7:0]    r1_sx, r1_sy;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_tx <= to_tex(in_ch.screen_x);
            r1_ty <= to_tex(in_ch.screen_y);
            r1_sx <= in_ch.screen_x;
            r1_sy <= in_ch.screen_y;
        end
    end

    // ---------------- stage 2: lid + polar reads ----------------
    logic [TW-1:0] lx1;
    logic [LID_AW-1:0] li1;
    logic signed [SUMW-1:0] ix1, iy1;
    logic in_iris1;
    logic [SW:0] scx1, scy1;
    assign lx1 = r_eye_side ? r1_tx : TW'(TEX_SIZE - 1) - r1_tx;
    assign li1 = LID_AW'(r1_ty) * LID_AW'(TEX_SIZE) + LID_AW'(lx1);
    assign ix1 = SUMW'(r_ofs_x) - SUMW'(MARGIN) + SUMW'(r1_tx);
    assign iy1 = SUMW'(r_ofs_y) - SUMW'(MARGIN) + SUMW'(r1_ty);
    assign in_iris1 = ix1 >= 0 && iy1 >= 0 && ix1 < SUMW'(IRIS_SIZE)
                      && iy1 < SUMW'(IRIS_SIZE);
    assign scx1 = (SW+1)'(r_ofs_x) + (SW+1)'(r1_tx);
    assign scy1 = (SW+1)'(r_ofs_y) + (SW+1)'(r1_ty);

    logic [POL_AW-1:0] pi1;
    assign pi1 = POL_AW'(iy1[IW-1:0]) * POL_AW'(IRIS_SIZE) + POL_AW'(ix1[IW-1:0]);

    logic [7:0]  upper_mem [LID_D];
    logic [7:0]  lower_mem [LID_D];
    logic [15:0] sclera_mem [SCL_D];
    logic [15:0] polar_mem [POL_D];
    logic [15:0] map_mem [MAP_D];

    logic ld_ok;
    always_comb begin
        case (in_ch.mode)
            MODE_UPPER, MODE_LOWER: ld_ok = 32'(in_ch.load_address) < 32'(LID_D);
            MODE_SCLERA: ld_ok = 32'(in_ch.load_address) < 32'(SCL_D);
            MODE_POLAR:  ld_ok = 32'(in_ch.load_address) < 32'(POL_D);
            MODE_MAP:    ld_ok = 32'(in_ch.load_address) < 32'(MAP_D);
            default:     ld_ok = 1'b0;
        endcase
    end

    // Loads are delayed to the stage where their store is read, so a render
    // sees exactly the loads taken before it.
    logic        r_w1, r_w2, r_w3;
    logic [2:0]  r_wm1, r_wm2, r_wm3;
    logic [15:0] r_wa1, r_wa2, r_wa3, r_wd1, r_wd2, r_wd3;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1 <= 1'b0; r_w2 <= 1'b0; r_w3 <= 1'b0;
        end else if (adv) begin
            r_w1 <= acc && ld_ok;
            r_w2 <= r_w1;
            r_w3 <= r_w2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wm1 <= in_ch.mode; r_wa1 <= in_ch.load_address; r_wd1 <= in_ch.load_data;
            r_wm2 <= r_wm1; r_wa2 <= r_wa1; r_wd2 <= r_wd1;
            r_wm3 <= r_wm2; r_wa3 <= r_wa2; r_wd3 <= r_wd2;
        end
    end

    // lid/polar read at stage 2 (data in stage 2 regs); written with wm1
    logic [7:0]  r2_up, r2_lo;
    logic [15:0] r2_pol;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_w1 && r_wm1 == MODE_UPPER) upper_mem[r_wa1[LID_AW-1:0]] <= r_wd1[7:0];
            if (r_w1 && r_wm1 == MODE_LOWER) lower_mem[r_wa1[LID_AW-1:0]] <= r_wd1[7:0];
            if (r_w1 && r_wm1 == MODE_POLAR) polar_mem[r_wa1[POL_AW-1:0]] <= r_wd1;
            r2_up  <= upper_mem[li1];
            r2_lo  <= lower_mem[li1];
            r2_pol <= polar_mem[pi1];
        end
    end

    logic          r2_in_iris;
    logic [SW:0]   r2_scx, r2_scy;
    logic [7:0]    r2_sx, r2_sy;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_in_iris <= in_iris1;
            r2_scx <= scx1; r2_scy <= scy1;
            r2_sx <= r1_sx; r2_sy <= r1_sy;
        end
    end

    // ---------------- stage 3: mask, radius scale ----------------
    logic [DPROD-1:0] r3_prod;
    logic [MWW-1:0]   r3_ang;
    logic             r3_mask, r3_in_iris;
    logic [SW:0]      r3_scx, r3_scy;
    logic [7:0]       r3_sx, r3_sy;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_prod <= DPROD'(r_iris_scale) * DPROD'(r2_pol[6:0]);
            r3_ang  <= MWW'((20'(IRIS_MAP_W) * 20'(r2_pol[15:7])) / 512);
            r3_mask <= (r2_lo <= r_lower_lim) || (r2_up <= r_upper_lim);
            r3_in_iris <= r2_in_iris;
            r3_scx <= r2_scx; r3_scy <= r2_scy;
            r3_sx <= r2_sx; r3_sy <= r2_sy;
        end
    end

    // ---------------- stage 4: iris / sclera read ----------------
    logic [DPROD-8:0] d3;
    logic use_map3, scl_ok3;
    logic [MAP_AW-1:0] ma3;
    logic [SCL_AW-1:0] sa3;
    assign d3 = r3_prod[DPROD-1:7];
    assign use_map3 = r3_in_iris && (32'(d3) < 32'(IRIS_MAP_H));
    assign ma3 = MAP_AW'(d3[MHW-1:0]) * MAP_AW'(IRIS_MAP_W) + MAP_AW'(r3_ang);
    assign scl_ok3 = 32'(r3_scx) < 32'(SCLERA_SIZE) && 32'(r3_scy) < 32'(SCLERA_SIZE);
    assign sa3 = SCL_AW'(r3_scy[SW-1:0]) * SCL_AW'(SCLERA_SIZE) + SCL_AW'(r3_scx[SW-1:0]);

    logic [15:0] r4_map, r4_scl;
    logic r4_mask, r4_use_map, r4_scl_ok;
    logic [7:0] r4_sx, r4_sy;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_w3 && r_wm3 == MODE_MAP)    map_mem[r_wa3[MAP_AW-1:0]] <= r_wd3;
            if (r_w3 && r_wm3 == MODE_SCLERA) sclera_mem[r_wa3[SCL_AW-1:0]] <= r_wd3;
            r4_map <= map_mem[ma3];
            r4_scl <= sclera_mem[sa3];
            r4_mask <= r3_mask; r4_use_map <= use_map3; r4_scl_ok <= scl_ok3;
            r4_sx <= r3_sx; r4_sy <= r3_sy;
        end
    end

    // ---------------- stage 5: select ----------------
    logic [15:0] col4;
    assign col4 = r4_mask ? 16'd0 : r4_use_map ? r4_map : r4_scl_ok ? r4_scl : 16'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (adv) r_v <= {r_v[2:0], is_render};
    end
    assign s5_push = adv && r_v[3];

    // ---------------- output skid (2 entries) ----------------
    logic r_q_wr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= '0; r_q_rd <= 1'b0; r_q_wr <= 1'b0;
        end else begin
            if (s5_push) r_q_wr <= ~r_q_wr;
            if (pop) r_q_rd <= ~r_q_rd;
            r_q_cnt <= r_q_cnt + 2'(s5_push) - 2'(pop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (s5_push) begin
            r_q_col[r_q_wr] <= col4;
            r_q_x[r_q_wr] <= r4_sx;
            r_q_y[r_q_wr] <= r4_sy;
        end
    end
    assign out_ch.valid = r_q_cnt != 2'd0;
    assign out_ch.pixel_color = r_q_col[r_q_rd];
    assign out_ch.pixel_x = r_q_x[r_q_rd];
    assign out_ch.pixel_y = r_q_y[r_q_rd];

    // ---------------- assertions ----------------
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= 2'd2) else $error("skid overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_cnt == 2'd2 && !pop) |-> !s5_push) else $error("push into full skid");
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_v)) else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

// ----- dv/tb_eye_pixel_compositor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_eye_pixel_compositor: self-checking regression of the eye renderer
// Runs directed and random load/render transactions over several register
// settings and idling patterns. Before each render the texture entries it
// reads are loaded if still unwritten. A scoreboard keeps its own copy of
// the stores and registers, predicts each rendered pixel and checks every
// output transaction in order.
// ----------------------------------------------------------------------------
module tb_eye_pixel_compositor;
    import epc_pkg::*;

    localparam int LID_N = TEX_SIZE_D * TEX_SIZE_D;
    localparam int SCL_N = SCLERA_SIZE_D * SCLERA_SIZE_D;
    localparam int POL_N = IRIS_SIZE_D * IRIS_SIZE_D;
    localparam int MAP_N = IRIS_MAP_W_D * IRIS_MAP_H_D;

    typedef struct packed {
        logic [15:0] color;
        logic [7:0]  px;
        logic [7:0]  py;
    } t_pixel;

    class pixel_scoreboard;
        bit [7:0]  upper_lid [LID_N];
        bit [7:0]  lower_lid [LID_N];
        bit [15:0] sclera [SCL_N];
        bit [15:0] polar [POL_N];
        bit [15:0] iris_map [MAP_N];
        bit        upper_ok [LID_N];
        bit        lower_ok [LID_N];
        bit        sclera_ok [SCL_N];
        bit        polar_ok [POL_N];
        bit        map_ok [MAP_N];
        bit        side;
        bit [9:0]  scale;
        bit [7:0]  ofs_x, ofs_y, thr_up, thr_lo;
        t_pixel    pending_px[$];
        int        errors;

        function new();
            side = 1'b0; scale = 10'd512; ofs_x = 8'd64; ofs_y = 8'd64;
            thr_up = 8'd0; thr_lo = 8'd0;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, bit [9:0] v);
            case (idx)
                REG_EYE_SIDE:  side = v[0];
                REG_IRIS_SCL:  scale = v;
                REG_SCL_OFS_X: ofs_x = v[7:0];
                REG_SCL_OFS_Y: ofs_y = v[7:0];
                REG_UPPER_THR: thr_up = v[7:0];
                REG_LOWER_THR: thr_lo = v[7:0];
                default: ;
            endcase
        endfunction

        function int lid_cut(int t);
            if (OUT_SIZE_D > TEX_SIZE_D && t < LID_LIMIT_CUT)
                return (t * TEX_SIZE_D) / OUT_SIZE_D;
            return t;
        endfunction

        function int tex_coord(int s);
            int v;
            v = (s * TEX_SIZE_D) / OUT_SIZE_D;
            return (v >= TEX_SIZE_D) ? TEX_SIZE_D - 1 : v;
        endfunction

        function bit [15:0] sclera_texel(int sx, int sy);
            if (sx < SCLERA_SIZE_D && sy < SCLERA_SIZE_D)
                return sclera[sy * SCLERA_SIZE_D + sx];
            return 16'd0;
        endfunction

        function bit lid_masked(int li);
            return int'(lower_lid[li]) <= lid_cut(int'(thr_lo)) ||
                   int'(upper_lid[li]) <= lid_cut(int'(thr_up));
        endfunction

        function bit [15:0] shade(int scr_x, int scr_y);
            int tx, ty, lx, li, ix, iy, margin, p, d, a;
            tx = tex_coord(scr_x);
            ty = tex_coord(scr_y);
            lx = side ? tx : TEX_SIZE_D - 1 - tx;
            li = ty * TEX_SIZE_D + lx;
            margin = (SCLERA_SIZE_D - IRIS_SIZE_D) / 2;
            ix = int'(ofs_x) - margin + tx;
            iy = int'(ofs_y) - margin + ty;
            if (lid_masked(li))
                return 16'd0;
            if (iy < 0 || iy >= IRIS_SIZE_D || ix < 0 || ix >= IRIS_SIZE_D)
                return sclera_texel(int'(ofs_x) + tx, int'(ofs_y) + ty);
            p = int'(polar[iy * IRIS_SIZE_D + ix]);
            d = (int'(scale) * (p & 'h7F)) / 128;
            if (d < IRIS_MAP_H_D) begin
                a = (IRIS_MAP_W_D * (p >> 7)) / 512;
                return iris_map[d * IRIS_MAP_W_D + a];
            end
            return sclera_texel(int'(ofs_x) + tx, int'(ofs_y) + ty);
        endfunction

        // first entry that rendering this pixel reads and no load has written
        function bit find_gap(int scr_x, int scr_y, output t_mode m, output int a);
            int tx, ty, lx, li, ix, iy, margin, sx, sy, p, d;
            tx = tex_coord(scr_x);
            ty = tex_coord(scr_y);
            lx = side ? tx : TEX_SIZE_D - 1 - tx;
            li = ty * TEX_SIZE_D + lx;
            margin = (SCLERA_SIZE_D - IRIS_SIZE_D) / 2;
            ix = int'(ofs_x) - margin + tx;
            iy = int'(ofs_y) - margin + ty;
            sx = int'(ofs_x) + tx;
            sy = int'(ofs_y) + ty;
            m = MODE_RENDER;
            a = 0;
            if (!lower_ok[li]) begin
                m = MODE_LOWER; a = li; return 1'b1;
            end
            if (!upper_ok[li]) begin
                m = MODE_UPPER; a = li; return 1'b1;
            end
            if (lid_masked(li))
                return 1'b0;
            if (iy >= 0 && iy < IRIS_SIZE_D && ix >= 0 && ix < IRIS_SIZE_D) begin
                if (!polar_ok[iy * IRIS_SIZE_D + ix]) begin
                    m = MODE_POLAR; a = iy * IRIS_SIZE_D + ix; return 1'b1;
                end
                p = int'(polar[iy * IRIS_SIZE_D + ix]);
                d = (int'(scale) * (p & 'h7F)) / 128;
                if (d < IRIS_MAP_H_D) begin
                    a = d * IRIS_MAP_W_D + (IRIS_MAP_W_D * (p >> 7)) / 512;
                    if (!map_ok[a]) begin
                        m = MODE_MAP; return 1'b1;
                    end
                    return 1'b0;
                end
            end
            if (sx < SCLERA_SIZE_D && sy < SCLERA_SIZE_D &&
                !sclera_ok[sy * SCLERA_SIZE_D + sx]) begin
                m = MODE_SCLERA; a = sy * SCLERA_SIZE_D + sx; return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note(bit [2:0] mode, bit [15:0] addr, bit [15:0] data,
                           bit [7:0] x, bit [7:0] y);
            t_pixel e;
            case (mode)
                MODE_UPPER: if (addr < LID_N) begin
                    upper_lid[addr] = data[7:0]; upper_ok[addr] = 1'b1;
                end
                MODE_LOWER: if (addr < LID_N) begin
                    lower_lid[addr] = data[7:0]; lower_ok[addr] = 1'b1;
                end
                MODE_SCLERA: if (addr < SCL_N) begin
                    sclera[addr] = data; sclera_ok[addr] = 1'b1;
                end
                MODE_POLAR: if (addr < POL_N) begin
                    polar[addr] = data; polar_ok[addr] = 1'b1;
                end
                MODE_MAP: if (addr < MAP_N) begin
                    iris_map[addr] = data; map_ok[addr] = 1'b1;
                end
                MODE_RENDER: begin
                    e.color = shade(int'(x), int'(y));
                    e.px = x;
                    e.py = y;
                    pending_px.push_back(e);
                end
                default: ;
            endcase
        endfunction

        function void check(t_pixel got);
            t_pixel e;
            if (pending_px.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d colour=%h", got.px, got.py, got.color);
                errors++;
                return;
            end
            e = pending_px.pop_front();
            if (got.color !== e.color) begin
                $error("pixel_color expected %h actual %h", e.color, got.color);
                errors++;
            end
            if (got.px !== e.px) begin
                $error("pixel_x expected %0d actual %0d", e.px, got.px);
                errors++;
            end
            if (got.py !== e.py) begin
                $error("pixel_y expected %0d actual %0d", e.py, got.py);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    epc_in_if  in_ch ();
    epc_out_if out_ch ();

    eye_pixel_compositor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    pixel_scoreboard sb = new();
    int send_idle = 0;
    int recv_stall = 0;
    int hold_off = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.load_address = '0;
        in_ch.load_data = '0;
        in_ch.screen_x = '0;
        in_ch.screen_y = '0;
        out_ch.ready = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off counted down here
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready)
                sb.check(t_pixel'{out_ch.pixel_color, out_ch.pixel_x, out_ch.pixel_y});
            if (in_ch.valid && in_ch.ready)
                sb.note(in_ch.mode, in_ch.load_address, in_ch.load_data,
                        in_ch.screen_x, in_ch.screen_y);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_txn(bit [2:0] mode, bit [15:0] addr, bit [15:0] data,
                            bit [7:0] x, bit [7:0] y);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.mode = mode;
        in_ch.load_address = addr;
        in_ch.load_data = data;
        in_ch.screen_x = x;
        in_ch.screen_y = y;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (sb.pending_px.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, bit [9:0] v);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic write_all(bit s, bit [9:0] scl, bit [7:0] ox, bit [7:0] oy,
                             bit [7:0] tu, bit [7:0] tl);
        write_reg(REG_EYE_SIDE, {9'd0, s});
        write_reg(REG_IRIS_SCL, scl);
        write_reg(REG_SCL_OFS_X, {2'd0, ox});
        write_reg(REG_SCL_OFS_Y, {2'd0, oy});
        write_reg(REG_UPPER_THR, {2'd0, tu});
        write_reg(REG_LOWER_THR, {2'd0, tl});
    endtask

    // polar word: half the time a small radius so the iris map is reached
    function automatic bit [15:0] polar_word();
        bit [15:0] w;
        w = 16'($urandom);
        if ($urandom_range(1)) w[6:0] = 7'($urandom_range(15));
        return w;
    endfunction

    // a small pool of coordinates, so that texture entries are reused
    function automatic bit [7:0] rand_coord();
        bit [7:0] c;
        case ($urandom_range(8))
            0: c = 8'd0;
            1: c = 8'd13;
            2: c = 8'd40;
            3: c = 8'd79;
            4: c = 8'd80;
            5: c = 8'd121;
            6: c = 8'd158;
            7: c = 8'd159;
            default: c = 8'd255;
        endcase
        return c;
    endfunction

    // loads whatever this pixel still needs, then renders it
    task automatic render_txn(bit [7:0] x, bit [7:0] y);
        t_mode m;
        int a;
        bit [15:0] d;
        while (sb.find_gap(int'(x), int'(y), m, a)) begin
            d = (m == MODE_POLAR) ? polar_word() : 16'($urandom);
            send_txn(m, 16'(a), d, 8'd0, 8'd0);
        end
        send_txn(MODE_RENDER, 16'($urandom), 16'($urandom), x, y);
    endtask

    task automatic random_txn();
        bit [2:0] m;
        bit [15:0] a, d;
        if ($urandom_range(99) < 70) begin
            render_txn(rand_coord(), rand_coord());
        end else begin
            m = 3'($urandom_range(7));
            a = 16'($urandom);
            if (m != MODE_SCLERA && $urandom_range(3) != 0) a[15:14] = 2'b00;
            d = (m == MODE_POLAR) ? polar_word() : 16'($urandom);
            if (m == MODE_RENDER)
                render_txn(rand_coord(), rand_coord());
            else
                send_txn(m, a, d, 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        #20_000_000;
        $display("eye_pixel_compositor regression: fail");
        $finish;
    end

    initial begin
        int idle_set [4][2];
        idle_set = '{'{0, 0}, '{50, 0}, '{0, 50}, '{20, 20}};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: corners, saturating coordinates, address extremes, unused modes
        render_txn(8'd0, 8'd0);
        render_txn(8'd159, 8'd159);
        render_txn(8'd255, 8'd255);
        render_txn(8'd0, 8'd255);
        render_txn(8'd80, 8'd80);
        for (int m = 0; m < 8; m++) begin
            if (m == int'(MODE_RENDER)) begin
                render_txn(8'hFF, 8'hFF);
                render_txn(8'h00, 8'h00);
            end else begin
                send_txn(3'(m), 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
                send_txn(3'(m), 16'h0000, 16'h0000, 8'h00, 8'h00);
            end
        end
        send_txn(MODE_UPPER, 16'(LID_N - 1), 16'h00FF, 8'd0, 8'd0);
        render_txn(8'd0, 8'd159);
        render_txn(8'd159, 8'd0);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_all(1'b1, 10'd0,    8'd0,   8'd0,   8'd0,   8'd0);
                1: write_all(1'b0, 10'd1023, 8'd255, 8'd255, 8'd199, 8'd0);
                2: write_all(1'b1, 10'd128,  8'd64,  8'd64,  8'd0,   8'd200);
                3: write_all(1'b0, 10'd512,  8'd100, 8'd30,  8'd255, 8'd20);
                default: write_all(1'($urandom), 10'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom_range(120)),
                                   8'($urandom_range(120)));
            endcase
            send_idle = idle_set[ph % 4][0];
            recv_stall = idle_set[ph % 4][1];
            if (ph == 4) begin
                // long receiver hold-off while renders keep coming
                hold_off = 400;
                repeat (60) render_txn(rand_coord(), rand_coord());
            end
            repeat (130) random_txn();
            drain();
        end

        send_idle = 0;
        recv_stall = 0;
        drain();
        if (sb.errors == 0 && sb.pending_px.size() == 0)
            $display("eye_pixel_compositor regression: pass");
        else
            $display("eye_pixel_compositor regression: fail");
        $finish;
    end
endmodule
